FILE: design/bat_pkg.sv
// Package for the box alpha tracker: value and counter types, command codes
// and the saturating fixed-point helpers used by the datapath.
// Depends on nothing.
package bat_pkg;

  localparam int VAL_W = 20;
  localparam int FRAC_BITS = 4;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int ALPHA_W = 9;
  localparam int CNT_OUT_W = 16;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_PREDICT = 2'd0;
  localparam cmd_t CMD_UPDATE = 2'd1;
  localparam cmd_t CMD_START = 2'd2;

  localparam val_t ONE_FX = val_t'(1 << FRAC_BITS);
  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam alpha_t ALPHA_RESET = alpha_t'(179);
  localparam alpha_t ALPHA_ONE = alpha_t'(256);

  // Saturate a 24-bit signed intermediate to the box value range.
  function automatic val_t sat_val(input logic signed [23:0] v);
    val_t r;
    if (v[23:VAL_W-1] == {(25-VAL_W){v[23]}}) begin
      r = v[VAL_W-1:0];
    end else begin
      r = v[23] ? VAL_MIN : VAL_MAX;
    end
    return r;
  endfunction

  // held + floor((a * (meas - held) + 128) / 256), which equals the
  // two-product blend because held * 256 is a whole multiple of 256.
  function automatic val_t blend(input val_t meas, input val_t held, input alpha_t a);
    logic signed [VAL_W:0] diff;
    logic signed [30:0] prod;
    logic signed [22:0] rnd;
    diff = (VAL_W+1)'(meas) - (VAL_W+1)'(held);
    prod = 31'(diff) * 31'($signed({1'b0, a})) + 31'sd128;
    rnd = prod[30:8];
    return sat_val(24'(held) + 24'(rnd));
  endfunction

endpackage

FILE: design/box_alpha_tracker.sv
// Top level of the box alpha tracker: input register, single-pass datapath
// on the track state, and result flag register. Depends on bat_pkg.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata: rect_x,y,w,h; tuser: command
// m_*       out  m_tvalid/m_tready   tdata: rect, hit/age/miss; tuser: rejected
// cfg_*     in   cfg_we              cfg_wdata: alpha_gain
//
// One transaction is taken per cycle while the output is not stalled;
// acceptance loads the input register, and the datapath then runs it into
// the track state, which offers the result. The datapath is one blend multiply per box term.
// Reset restores the default gain, a unit box and zero counters.
// A stalled output holds the input register, and the slave side keeps
// s_tready deasserted while that register holds a transaction.
module box_alpha_tracker
  import bat_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // rect_x, rect_y, rect_w, rect_h
  input  logic [1:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // out_x, out_y, out_w, out_h, hit_total,
                                  // age_total, miss_run
  output logic         m_tuser,   // rejected
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata  // alpha_gain
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  alpha_t alpha;

  // Input register, with the measured centres already worked out.
  logic pipe_valid;
  cmd_t pipe_cmd;
  val_t pipe_x, pipe_y, pipe_w, pipe_h, pipe_cx, pipe_cy;

  // Track state.
  val_t cx, cy, sw, sh, vcx, vcy, vw, vh;
  val_t shown_x, shown_y, shown_w, shown_h;
  cnt_t hit_cnt, age_cnt, miss_cnt;
  logic rejected;

  val_t cx_next, cy_next, sw_next, sh_next, vcx_next, vcy_next, vw_next, vh_next;
  val_t shown_x_next, shown_y_next, shown_w_next, shown_h_next;
  cnt_t hit_cnt_next, age_cnt_next, miss_cnt_next;
  logic rejected_next;

  val_t in_x, in_y, in_w, in_h;
  val_t pcx, pcy, psw, psh;
  logic advance;

  assign advance = pipe_valid && (!m_tvalid || m_tready);
  assign s_tready = !pipe_valid || advance;

  assign in_x = s_tdata[19:0];
  assign in_y = s_tdata[39:20];
  assign in_w = s_tdata[59:40];
  assign in_h = s_tdata[79:60];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha <= (cfg_wdata > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (s_tready) begin
      pipe_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pipe_cmd <= s_tuser;
      pipe_x <= in_x;
      pipe_y <= in_y;
      pipe_w <= in_w;
      pipe_h <= in_h;
      pipe_cx <= sat_val(24'(in_x) + 24'(in_w >>> 1));
      pipe_cy <= sat_val(24'(in_y) + 24'(in_h >>> 1));
    end
  end

  // Predicted box, used only by a predict tick.
  always_comb begin
    pcx = sat_val(24'(cx) + 24'(vcx));
    pcy = sat_val(24'(cy) + 24'(vcy));
    psw = sat_val(24'(sw) + 24'(vw));
    psh = sat_val(24'(sh) + 24'(vh));
    if (psw < ONE_FX) begin
      psw = ONE_FX;
    end
    if (psh < ONE_FX) begin
      psh = ONE_FX;
    end
  end

  always_comb begin
    cx_next = cx;
    cy_next = cy;
    sw_next = sw;
    sh_next = sh;
    vcx_next = vcx;
    vcy_next = vcy;
    vw_next = vw;
    vh_next = vh;
    shown_x_next = shown_x;
    shown_y_next = shown_y;
    shown_w_next = shown_w;
    shown_h_next = shown_h;
    hit_cnt_next = hit_cnt;
    age_cnt_next = age_cnt;
    miss_cnt_next = miss_cnt;
    rejected_next = 1'b0;
    unique case (pipe_cmd)
      CMD_START: begin
        cx_next = pipe_cx;
        cy_next = pipe_cy;
        sw_next = (pipe_w > ONE_FX) ? pipe_w : ONE_FX;
        sh_next = (pipe_h > ONE_FX) ? pipe_h : ONE_FX;
        vcx_next = '0;
        vcy_next = '0;
        vw_next = '0;
        vh_next = '0;
        shown_x_next = pipe_x;
        shown_y_next = pipe_y;
        shown_w_next = pipe_w;
        shown_h_next = pipe_h;
        hit_cnt_next = '0;
        age_cnt_next = '0;
        miss_cnt_next = '0;
      end
      CMD_PREDICT: begin
        cx_next = pcx;
        cy_next = pcy;
        sw_next = psw;
        sh_next = psh;
        age_cnt_next = (&age_cnt) ? age_cnt : age_cnt + cnt_t'(1);
        miss_cnt_next = (&miss_cnt) ? miss_cnt : miss_cnt + cnt_t'(1);
        shown_x_next = sat_val(24'(pcx) - 24'(psw >>> 1));
        shown_y_next = sat_val(24'(pcy) - 24'(psh >>> 1));
        shown_w_next = psw;
        shown_h_next = psh;
      end
      CMD_UPDATE: begin
        if (pipe_w <= 0 || pipe_h <= 0) begin
          rejected_next = 1'b1;
        end else begin
          // Half the difference always fits the value range, so no clamp.
          if (hit_cnt != '0) begin
            vcx_next = val_t'(((VAL_W+1)'(pipe_cx) - (VAL_W+1)'(cx)) >>> 1);
            vcy_next = val_t'(((VAL_W+1)'(pipe_cy) - (VAL_W+1)'(cy)) >>> 1);
            vw_next = val_t'(((VAL_W+1)'(pipe_w) - (VAL_W+1)'(sw)) >>> 1);
            vh_next = val_t'(((VAL_W+1)'(pipe_h) - (VAL_W+1)'(sh)) >>> 1);
          end
          cx_next = blend(pipe_cx, cx, alpha);
          cy_next = blend(pipe_cy, cy, alpha);
          sw_next = blend(pipe_w, sw, alpha);
          sh_next = blend(pipe_h, sh, alpha);
          shown_x_next = pipe_x;
          shown_y_next = pipe_y;
          shown_w_next = pipe_w;
          shown_h_next = pipe_h;
          hit_cnt_next = (&hit_cnt) ? hit_cnt : hit_cnt + cnt_t'(1);
          miss_cnt_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
      sw <= ONE_FX;
      sh <= ONE_FX;
      vcx <= '0;
      vcy <= '0;
      vw <= '0;
      vh <= '0;
      shown_x <= '0;
      shown_y <= '0;
      shown_w <= '0;
      shown_h <= '0;
      hit_cnt <= '0;
      age_cnt <= '0;
      miss_cnt <= '0;
      rejected <= 1'b0;
    end else if (advance) begin
      cx <= cx_next;
      cy <= cy_next;
      sw <= sw_next;
      sh <= sh_next;
      vcx <= vcx_next;
      vcy <= vcy_next;
      vw <= vw_next;
      vh <= vh_next;
      shown_x <= shown_x_next;
      shown_y <= shown_y_next;
      shown_w <= shown_w_next;
      shown_h <= shown_h_next;
      hit_cnt <= hit_cnt_next;
      age_cnt <= age_cnt_next;
      miss_cnt <= miss_cnt_next;
      rejected <= rejected_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The shown rectangle and counters only move on a transaction through the
  // datapath, so they double as the output register.
  assign m_tdata = {CNT_OUT_W'(miss_cnt), CNT_OUT_W'(age_cnt), CNT_OUT_W'(hit_cnt),
                    shown_h, shown_w, shown_y, shown_x};
  assign m_tuser = rejected;

  a_size_positive: assert property (@(posedge clk) disable iff (rst)
    sw > 0 && sh > 0)
    else $error("tracked box size is not positive");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("datapath transaction produced no result");

  a_reject_on_update: assert property (@(posedge clk) disable iff (rst)
    advance && rejected_next |-> pipe_cmd == CMD_UPDATE)
    else $error("rejection raised for a command other than update");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    pipe_valid && !advance |=> pipe_valid && $stable(pipe_cmd) && $stable(pipe_cx))
    else $error("input register lost a stalled transaction");

endmodule
